@@ rtl/event_journal_with_error_edges_macros.svh @@
// Assertion macros used by the checker of the event journal.
// Both sample on clk and are switched off while rst_n is low.
`ifndef EVENT_JOURNAL_WITH_ERROR_EDGES_MACROS_SVH
`define EVENT_JOURNAL_WITH_ERROR_EDGES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EJ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ej_pkg.sv @@
package ej_pkg;

    localparam int RECORDS           = 64;
    localparam int NUM_FLAGS         = 64;
    localparam int FIRST_LOGGED_FLAG = 32;

    localparam int IDX_W = $clog2(RECORDS);

    localparam logic [31:0] TIME_ALL_ONES = 32'hffff_ffff;

    typedef enum logic [2:0] {
        OP_SAVE     = 3'd0,
        OP_READ     = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_SET_FLAG = 3'd3,
        OP_CLR_FLAG = 3'd4,
        OP_ERR_SCAN = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_FLAG,
        ST_DONE
    } state_t;

endpackage

@@ rtl/event_journal_with_error_edges.sv @@
// Event journal with error-edge logging. The block keeps RECORDS time-stamped
// records (time, channel, event, data) in one synchronous memory (one read and
// one write port) and takes one operation item at a time, chosen by the opcode
// in s_axis_tuser: save an event, read a record, clear the journal, set or
// clear an error flag, or run an error scan. Every item gives exactly one result
// item. A save walks the whole journal through the memory read port, one entry
// per cycle, to find the first empty entry (time 0 or all ones) or, failing
// that, the entry after the newest one. An error scan steps through the flags
// from FIRST_LOGGED_FLAG upward, one flag per cycle while no save is under way,
// and performs such a save for every flag that has risen since the previous
// scan. Clearing the journal, at reset or by the clear operation, takes effect
// at once through one valid bit per entry; an entry without its valid bit reads
// as an all-zero record. A new item is taken while the previous result still
// waits on the output register.
module event_journal_with_error_edges
    import ej_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_seconds[31:0], channel[39:32], event_code[47:40], event_data[63:48],
    // record_index[71:64], flag_index[77:72], zero padding[79:78]
    input  logic [79:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rec_time[31:0], rec_channel[39:32], rec_event[47:40], rec_data[63:48],
    // flag_state[64], slot_written[70:65], logged_count[77:71], zero padding[79:78]
    output logic [79:0] m_axis_tdata,
    // status[0]
    output logic [0:0]  m_axis_tuser
);

    localparam logic [5:0]       LAST_FLAG  = 6'(NUM_FLAGS - 1);
    localparam logic [5:0]       FIRST_FLAG = 6'(FIRST_LOGGED_FLAG);
    localparam logic             SCAN_ANY   = (FIRST_LOGGED_FLAG < NUM_FLAGS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RECORDS - 1);

    // Journal memory and the valid bit of each entry.
    logic [63:0]        mem [RECORDS];
    logic [63:0]        mem_q;
    logic               vld_q;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [63:0]        wr_data;

    logic [RECORDS-1:0] valid_reg, valid_next;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [31:0]        now_reg, now_next;
    logic [7:0]         chan_reg, chan_next;
    logic [7:0]         evt_reg, evt_next;
    logic [15:0]        dat_reg, dat_next;
    logic [7:0]         ridx_reg, ridx_next;
    logic [5:0]         fidx_reg, fidx_next;

    logic [63:0]        flags_reg, flags_next;
    logic [63:0]        prev_reg, prev_next;

    // Journal walk: reads are issued from scan_ptr, results are judged in the next cycle.
    logic [IDX_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic               eval_en_reg, eval_en_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hole_reg, hole_next;
    logic [IDX_W-1:0]   newest_reg, newest_next;
    logic [31:0]        maxtime_reg, maxtime_next;

    logic [5:0]         flag_ptr_reg, flag_ptr_next;
    logic [6:0]         count_reg, count_next;
    logic [IDX_W-1:0]   last_slot_reg, last_slot_next;

    logic               out_valid_reg, out_valid_next;
    logic [79:0]        out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;

    logic               in_accept;
    logic [31:0]        ev_time;
    logic               ev_empty;
    logic [IDX_W-1:0]   target;
    logic [63:0]        rise_vec;
    logic               res_status;
    logic [63:0]        res_rec;
    logic               res_flag;
    logic               fidx_ok;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign rd_en   = (state_reg == ST_SCAN) || (in_accept && (s_axis_tuser == OP_READ));
    assign rd_addr = (state_reg == ST_SCAN) ? scan_ptr_reg : IDX_W'(s_axis_tdata[71:64]);

    // An entry never written since the last clear reads as time zero, so it is empty.
    assign ev_time  = vld_q ? mem_q[31:0] : 32'h0;
    assign ev_empty = (ev_time == 32'h0) || (ev_time == TIME_ALL_ONES);
    assign target   = found_reg ? hole_reg :
                      ((newest_reg == LAST_IDX) ? '0 : newest_reg + 1'b1);
    assign rise_vec = flags_reg & ~prev_reg;

    assign fidx_ok    = (7'(fidx_reg) < 7'(NUM_FLAGS));
    assign res_status = (op_reg == OP_READ) && (9'(ridx_reg) >= 9'(RECORDS));
    assign res_rec    = ((op_reg == OP_READ) && !res_status && vld_q) ? mem_q : 64'h0;
    assign res_flag   = fidx_ok && flags_reg[fidx_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
            vld_q <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            flags_reg     <= '0;
            prev_reg      <= '0;
            eval_en_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_ptr_reg  <= '0;
            flag_ptr_reg  <= '0;
            count_reg     <= '0;
            op_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            flags_reg     <= flags_next;
            prev_reg      <= prev_next;
            eval_en_reg   <= eval_en_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            scan_ptr_reg  <= scan_ptr_next;
            flag_ptr_reg  <= flag_ptr_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        chan_reg      <= chan_next;
        evt_reg       <= evt_next;
        dat_reg       <= dat_next;
        ridx_reg      <= ridx_next;
        fidx_reg      <= fidx_next;
        eval_idx_reg  <= eval_idx_next;
        hole_reg      <= hole_next;
        newest_reg    <= newest_next;
        maxtime_reg   <= maxtime_next;
        last_slot_reg <= last_slot_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        chan_next      = chan_reg;
        evt_next       = evt_reg;
        dat_next       = dat_reg;
        ridx_next      = ridx_reg;
        fidx_next      = fidx_reg;
        valid_next     = valid_reg;
        flags_next     = flags_reg;
        prev_next      = prev_reg;
        scan_ptr_next  = scan_ptr_reg;
        eval_en_next   = (state_reg == ST_SCAN);
        eval_idx_next  = scan_ptr_reg;
        found_next     = found_reg;
        hole_next      = hole_reg;
        newest_next    = newest_reg;
        maxtime_next   = maxtime_reg;
        flag_ptr_next  = flag_ptr_reg;
        count_next     = count_reg;
        last_slot_next = last_slot_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        wr_en          = 1'b0;
        wr_addr        = target;
        wr_data        = (op_reg == OP_ERR_SCAN) ?
                         {16'h0, 2'b00, flag_ptr_reg, 8'h0, now_reg} :
                         {dat_reg, evt_reg, chan_reg, now_reg};

        // Judge the entry read in the previous cycle; the first empty one wins.
        if (eval_en_reg && !found_reg)
        begin
            if (ev_empty)
            begin
                found_next = 1'b1;
                hole_next  = eval_idx_reg;
            end
            else if (ev_time >= maxtime_reg)
            begin
                maxtime_next = ev_time;
                newest_next  = eval_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = s_axis_tuser;
                    now_next       = s_axis_tdata[31:0];
                    chan_next      = s_axis_tdata[39:32];
                    evt_next       = s_axis_tdata[47:40];
                    dat_next       = s_axis_tdata[63:48];
                    ridx_next      = s_axis_tdata[71:64];
                    fidx_next      = s_axis_tdata[77:72];
                    count_next     = '0;
                    last_slot_next = '0;
                    state_next     = ST_DONE;
                    unique case (s_axis_tuser)
                        OP_SAVE:
                        begin
                            scan_ptr_next = '0;
                            found_next    = 1'b0;
                            maxtime_next  = '0;
                            newest_next   = '0;
                            state_next    = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        OP_SET_FLAG:
                        begin
                            if (7'(s_axis_tdata[77:72]) < 7'(NUM_FLAGS))
                            begin
                                flags_next[s_axis_tdata[77:72]] = 1'b1;
                            end
                        end
                        OP_CLR_FLAG:
                        begin
                            if (7'(s_axis_tdata[77:72]) < 7'(NUM_FLAGS))
                            begin
                                flags_next[s_axis_tdata[77:72]] = 1'b0;
                            end
                        end
                        OP_ERR_SCAN:
                        begin
                            flag_ptr_next = FIRST_FLAG;
                            if (SCAN_ANY)
                            begin
                                state_next = ST_FLAG;
                            end
                            else
                            begin
                                prev_next = flags_reg;
                            end
                        end
                        default:
                        begin
                            // Reads need only the memory access issued above;
                            // unused opcodes change nothing.
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                scan_ptr_next = scan_ptr_reg + 1'b1;
                if (scan_ptr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                wr_en                = 1'b1;
                valid_next[target]   = 1'b1;
                last_slot_next       = target;
                count_next           = count_reg + 1'b1;
                if (op_reg == OP_ERR_SCAN)
                begin
                    if (flag_ptr_reg == LAST_FLAG)
                    begin
                        prev_next  = flags_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        flag_ptr_next = flag_ptr_reg + 1'b1;
                        state_next    = ST_FLAG;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_FLAG:
            begin
                if (rise_vec[flag_ptr_reg])
                begin
                    scan_ptr_next = '0;
                    found_next    = 1'b0;
                    maxtime_next  = '0;
                    newest_next   = '0;
                    state_next    = ST_SCAN;
                end
                else if (flag_ptr_reg == LAST_FLAG)
                begin
                    prev_next  = flags_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    flag_ptr_next = flag_ptr_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = res_status;
                    out_data_next  = {2'b00, count_reg, 6'(last_slot_reg), res_flag, res_rec};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ej_checker.sv @@
`include "event_journal_with_error_edges_macros.svh"

module ej_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic in_hs;
    logic out_stall;

    assign in_hs     = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A waiting result holds until it is taken.
    `EJ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Items are worked one at a time: the input closes right after an item is taken.
    `EJ_ASSERT_NEXT(a_one_at_a_time, in_hs, !s_axis_tready, "input open right after an accepted item")

    // A failed read carries no record and writes nothing.
    `EJ_ASSERT_SAME(a_bad_read, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[63:0] == 64'h0) && (m_axis_tdata[77:65] == 13'h0), "failed read with record or write fields")

    // A result that carries record contents comes from a read, which writes nothing.
    `EJ_ASSERT_SAME(a_read_no_write, m_axis_tvalid && (m_axis_tdata[63:0] != 64'h0), m_axis_tdata[77:65] == 13'h0, "read result reports written records")

endmodule

bind event_journal_with_error_edges ej_checker u_ej_checker (.*);
